@@ src/lkvc_pkg.sv @@
// lkvc_pkg: shared constants, types and controller commands for the lru key-value cache
// no dependencies; used by lkvc_ctrl, lkvc_datapath and lru_key_value_cache_unit
`timescale 1ns / 1ps
`default_nettype none

package lkvc_pkg;

    // field widths fixed by the item format
    localparam int KEY_W   = 32;
    localparam int VALUE_W = 64;

    // default number of entries
    localparam int DEFAULT_CAPACITY = 4;

    // operation codes
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_UPDATE
    } ctrl_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;    // capture the input item
        logic search;  // compare keys, pick the entry, read its value
        logic update;  // write the entry, age the others, register the result
    } ctrl_cmd_t;

endpackage

`default_nettype wire

@@ src/lkvc_ctrl.sv @@
// lkvc_ctrl: controller state machine sequencing one cache operation at a time
// depends on lkvc_pkg (state enum, command struct)
`timescale 1ns / 1ps
`default_nettype none

module lkvc_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    output lkvc_pkg::ctrl_cmd_t      cmd
);

    lkvc_pkg::ctrl_state_t state_reg;
    lkvc_pkg::ctrl_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lkvc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lkvc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = lkvc_pkg::ST_SEARCH;
                end
            end
            lkvc_pkg::ST_SEARCH:
            begin
                state_next = lkvc_pkg::ST_UPDATE;
            end
            lkvc_pkg::ST_UPDATE:
            begin
                state_next = lkvc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lkvc_pkg::ST_IDLE;
            end
        endcase
    end

    // command and status outputs
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            lkvc_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            lkvc_pkg::ST_SEARCH:
            begin
                cmd.search = 1'b1;
            end
            lkvc_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ src/lkvc_datapath.sv @@
// lkvc_datapath: key lanes with parallel compare, age ranks, value memory and result registers
// depends on lkvc_pkg (widths, operation codes, command struct)
`timescale 1ns / 1ps
`default_nettype none

module lkvc_datapath #(
    parameter int CAPACITY = lkvc_pkg::DEFAULT_CAPACITY
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire lkvc_pkg::ctrl_cmd_t                 cmd,
    input  wire logic                                operation,
    input  wire logic signed [lkvc_pkg::KEY_W-1:0]   key,
    input  wire logic [lkvc_pkg::VALUE_W-1:0]        write_value,
    output logic                                     done,
    output logic                                     hit,
    output logic [lkvc_pkg::VALUE_W-1:0]             read_value,
    output logic                                     evicted,
    output logic signed [lkvc_pkg::KEY_W-1:0]        evicted_key
);

    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int RANK_W = IDX_W;
    localparam logic [RANK_W-1:0] OLDEST_RANK = RANK_W'(CAPACITY - 1);

    // captured input item
    logic                          op_reg;
    logic [lkvc_pkg::KEY_W-1:0]    key_reg;
    logic [lkvc_pkg::VALUE_W-1:0]  wval_reg;

    // per-entry lanes
    logic [CAPACITY-1:0]           valid_reg;
    logic [lkvc_pkg::KEY_W-1:0]    ekey_reg  [CAPACITY];
    logic [RANK_W-1:0]             rank_reg  [CAPACITY];
    logic [RANK_W-1:0]             rank_next [CAPACITY];

    // value store
    logic [lkvc_pkg::VALUE_W-1:0]  value_mem [CAPACITY];
    logic [lkvc_pkg::VALUE_W-1:0]  rd_data_reg;

    // search results
    logic                          match_any;
    logic [IDX_W-1:0]              match_idx;
    logic                          free_any;
    logic [IDX_W-1:0]              free_idx;
    logic [IDX_W-1:0]              victim_idx;
    logic [IDX_W-1:0]              sel_idx;

    logic                          hit_reg;
    logic                          free_reg;
    logic [IDX_W-1:0]              idx_reg;
    logic [lkvc_pkg::KEY_W-1:0]    vkey_reg;

    // result registers
    logic                          done_reg;
    logic                          hit_out_reg;
    logic [lkvc_pkg::VALUE_W-1:0]  rval_out_reg;
    logic                          evict_out_reg;
    logic [lkvc_pkg::KEY_W-1:0]    ekey_out_reg;

    logic                          is_put;
    logic                          touch;
    logic                          was_valid;
    logic [RANK_W-1:0]             old_rank;

    // capture the item on transfer
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= operation;
            key_reg  <= key;
            wval_reg <= write_value;
        end
    end

    // parallel key compare with first-match, first-free and oldest-entry encoders
    always_comb
    begin
        match_any  = 1'b0;
        match_idx  = '0;
        free_any   = 1'b0;
        free_idx   = '0;
        victim_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && (ekey_reg[i] == key_reg))
            begin
                match_any = 1'b1;
                match_idx = IDX_W'(i);
            end
            if (!valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
            if (rank_reg[i] == OLDEST_RANK)
            begin
                victim_idx = IDX_W'(i);
            end
        end
    end

    // entry chosen for this operation
    always_comb
    begin
        priority if (match_any)
        begin
            sel_idx = match_idx;
        end
        else if (free_any)
        begin
            sel_idx = free_idx;
        end
        else
        begin
            sel_idx = victim_idx;
        end
    end

    // register search outcome
    always_ff @(posedge clk)
    begin
        if (cmd.search)
        begin
            hit_reg  <= match_any;
            free_reg <= free_any;
            idx_reg  <= sel_idx;
            vkey_reg <= ekey_reg[victim_idx];
        end
    end

    // value memory: registered read during search, write during update
    always_ff @(posedge clk)
    begin
        if (cmd.search)
        begin
            rd_data_reg <= value_mem[sel_idx];
        end
        if (cmd.update && is_put)
        begin
            value_mem[idx_reg] <= wval_reg;
        end
    end

    assign is_put    = (op_reg == lkvc_pkg::OP_PUT);
    assign touch     = hit_reg || is_put;
    assign was_valid = valid_reg[idx_reg];
    assign old_rank  = rank_reg[idx_reg];

    // age ranks: touched entry newest; younger valid ones (all on a fill) grow one older
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (IDX_W'(i) == idx_reg)
            begin
                rank_next[i] = '0;
            end
            else if (valid_reg[i] && (!was_valid || (rank_reg[i] < old_rank)))
            begin
                rank_next[i] = rank_reg[i] + RANK_W'(1);
            end
        end
    end

    // valid bits and ranks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            for (int i = 0; i < CAPACITY; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else if (cmd.update && touch)
        begin
            valid_reg[idx_reg] <= 1'b1;
            for (int i = 0; i < CAPACITY; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    // key lanes written on a put miss
    always_ff @(posedge clk)
    begin
        if (cmd.update && is_put && !hit_reg)
        begin
            ekey_reg[idx_reg] <= key_reg;
        end
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            hit_out_reg   <= hit_reg;
            rval_out_reg  <= (hit_reg && !is_put) ? rd_data_reg : '0;
            evict_out_reg <= is_put && !hit_reg && !free_reg;
            ekey_out_reg  <= (is_put && !hit_reg && !free_reg) ? vkey_reg : '0;
        end
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.update;
        end
    end

    assign done        = done_reg;
    assign hit         = hit_out_reg;
    assign read_value  = rval_out_reg;
    assign evicted     = evict_out_reg;
    assign evicted_key = signed'(ekey_out_reg);

endmodule

`default_nettype wire

@@ src/lru_key_value_cache_unit.sv @@
// lru_key_value_cache_unit: top level of the fully associative lru key-value cache
// depends on lkvc_pkg, lkvc_ctrl and lkvc_datapath
//
// channel   signals                                   transfer condition
// -------   ---------------------------------------   ---------------------------
// command   start, busy, operation, key, write_value  start high while busy low
// result    done, hit, read_value, evicted,           done high, one cycle
//           evicted_key
//
// each operation runs through transfer, key search with value read,
// and update; the result strobe appears in the cycle after the update,
// together with busy falling, so a new command may be issued in that cycle.
// reset clears all valid bits and ranks; key and value storage are not cleared.
// the receiver cannot stall results.
`timescale 1ns / 1ps
`default_nettype none

module lru_key_value_cache_unit #(
    parameter int CAPACITY = lkvc_pkg::DEFAULT_CAPACITY
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic                                operation,
    input  wire logic signed [lkvc_pkg::KEY_W-1:0]   key,
    input  wire logic [lkvc_pkg::VALUE_W-1:0]        write_value,
    output logic                                     done,
    output logic                                     hit,
    output logic [lkvc_pkg::VALUE_W-1:0]             read_value,
    output logic                                     evicted,
    output logic signed [lkvc_pkg::KEY_W-1:0]        evicted_key
);

    lkvc_pkg::ctrl_cmd_t cmd;

    // sequencing
    lkvc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    // storage, search and result
    lkvc_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .operation   (operation),
        .key         (key),
        .write_value (write_value),
        .done        (done),
        .hit         (hit),
        .read_value  (read_value),
        .evicted     (evicted),
        .evicted_key (evicted_key)
    );

endmodule

`default_nettype wire

@@ dv/tb_lru_key_value_cache_unit.sv @@
// tb_lru_key_value_cache_unit: self-checking testbench for the lru key-value cache
// depends on lkvc_pkg and lru_key_value_cache_unit; directed and random get/put traffic,
// results checked against an in-bench model of the cache contents and age ranks
`timescale 1ns / 1ps

module tb_lru_key_value_cache_unit;

    localparam int CAPACITY    = lkvc_pkg::DEFAULT_CAPACITY;
    localparam int AGE_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_CMDS = 1750;
    localparam int MAX_GAP     = 12;

    typedef struct {
        logic                               op;
        logic signed [lkvc_pkg::KEY_W-1:0]  key;
        logic [lkvc_pkg::VALUE_W-1:0]       wval;
        int                                 gap;
    } cache_cmd_t;

    typedef struct {
        logic                               hit;
        logic [lkvc_pkg::VALUE_W-1:0]       read_value;
        logic                               evicted;
        logic signed [lkvc_pkg::KEY_W-1:0]  evicted_key;
    } cache_reply_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               start = 1'b0;
    logic                               operation = lkvc_pkg::OP_GET;
    logic signed [lkvc_pkg::KEY_W-1:0]  key = '0;
    logic [lkvc_pkg::VALUE_W-1:0]       write_value = '0;
    logic                               busy;
    logic                               done;
    logic                               hit;
    logic [lkvc_pkg::VALUE_W-1:0]       read_value;
    logic                               evicted;
    logic signed [lkvc_pkg::KEY_W-1:0]  evicted_key;

    cache_cmd_t   pending_cmds[$];
    cache_reply_t replies_due[$];
    logic         cmd_taken = 1'b0;
    bit           failed = 1'b0;
    int           cycle_count = 0;

    // shadow copy of the cache contents
    logic                               slot_used [CAPACITY];
    logic signed [lkvc_pkg::KEY_W-1:0]  slot_key  [CAPACITY];
    logic [lkvc_pkg::VALUE_W-1:0]       slot_val  [CAPACITY];
    logic [AGE_W-1:0]                   slot_age  [CAPACITY];

    lru_key_value_cache_unit #(
        .CAPACITY(CAPACITY)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .operation(operation),
        .key(key),
        .write_value(write_value),
        .done(done),
        .hit(hit),
        .read_value(read_value),
        .evicted(evicted),
        .evicted_key(evicted_key)
    );

    // clock
    always #5 clk = ~clk;

    // make one slot the youngest; younger valid slots (or all, for a fresh fill) age by one
    function automatic void refresh_slot(int idx, bit was_used);
        logic [AGE_W-1:0] old_age;
        old_age = slot_age[idx];
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (i != idx && slot_used[i] && (!was_used || slot_age[i] < old_age))
                slot_age[i] = slot_age[i] + 1'b1;
        end
        slot_age[idx]  = '0;
        slot_used[idx] = 1'b1;
    endfunction

    // apply one get/put to the shadow cache and return what the block should answer
    function automatic cache_reply_t cache_access(cache_cmd_t c);
        cache_reply_t r;
        int found;
        int free_idx;
        int victim;
        r        = '{1'b0, '0, 1'b0, '0};
        found    = -1;
        free_idx = -1;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (slot_used[i])
            begin
                if (found < 0 && slot_key[i] == c.key)
                    found = i;
            end
            else if (free_idx < 0)
                free_idx = i;
        end
        if (found >= 0)
        begin
            r.hit = 1'b1;
            if (c.op == lkvc_pkg::OP_PUT)
                slot_val[found] = c.wval;
            else
                r.read_value = slot_val[found];
            refresh_slot(found, 1'b1);
        end
        else if (c.op == lkvc_pkg::OP_PUT)
        begin
            if (free_idx >= 0)
            begin
                slot_key[free_idx] = c.key;
                slot_val[free_idx] = c.wval;
                refresh_slot(free_idx, 1'b0);
            end
            else
            begin
                // full: replace the oldest, lowest index on a tie
                victim = 0;
                for (int i = 1; i < CAPACITY; i++)
                begin
                    if (slot_age[i] > slot_age[victim])
                        victim = i;
                end
                r.evicted        = 1'b1;
                r.evicted_key    = slot_key[victim];
                slot_key[victim] = c.key;
                slot_val[victim] = c.wval;
                refresh_slot(victim, 1'b1);
            end
        end
        return r;
    endfunction

    function automatic void queue_cmd(logic op, logic [lkvc_pkg::KEY_W-1:0] k,
                                      logic [lkvc_pkg::VALUE_W-1:0] v, int gap);
        cache_cmd_t c;
        c.op   = op;
        c.key  = k;
        c.wval = v;
        c.gap  = gap;
        pending_cmds.push_back(c);
    endfunction

    function automatic logic [lkvc_pkg::KEY_W-1:0] pick_key_extreme();
        case ($urandom_range(4))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [lkvc_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return '1;
            1:       return '0;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // driver: present the next command at the falling edge, hold it until the transfer
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (start && !cmd_taken)
            begin
                // still waiting for the transfer
            end
            else if (pending_cmds.size() == 0)
            begin
                start <= 1'b0;
            end
            else if (pending_cmds[0].gap > 0)
            begin
                pending_cmds[0].gap = pending_cmds[0].gap - 1;
                start       <= 1'b0;
                operation   <= 1'($urandom_range(1));
                key         <= $urandom;
                write_value <= {$urandom, $urandom};
            end
            else
            begin
                start       <= 1'b1;
                operation   <= pending_cmds[0].op;
                key         <= pending_cmds[0].key;
                write_value <= pending_cmds[0].wval;
                void'(pending_cmds.pop_front());
            end
        end
    end

    // monitor: check the result strobe, then record a command transfer
    always @(posedge clk)
    begin
        cache_reply_t want;
        cache_cmd_t   c;
        if (rst_n)
        begin
            if (done)
            begin
                if (replies_due.size() == 0)
                begin
                    $error("result with no command outstanding");
                    failed = 1'b1;
                end
                else
                begin
                    want = replies_due.pop_front();
                    if (hit !== want.hit)
                    begin
                        $error("hit: expected %0d, got %0d", want.hit, hit);
                        failed = 1'b1;
                    end
                    if (read_value !== want.read_value)
                    begin
                        $error("read_value: expected %h, got %h", want.read_value, read_value);
                        failed = 1'b1;
                    end
                    if (evicted !== want.evicted)
                    begin
                        $error("evicted: expected %0d, got %0d", want.evicted, evicted);
                        failed = 1'b1;
                    end
                    if (evicted_key !== want.evicted_key)
                    begin
                        $error("evicted_key: expected %h, got %h", want.evicted_key,
                               evicted_key);
                        failed = 1'b1;
                    end
                end
            end
            if (start && !busy)
            begin
                c.op   = operation;
                c.key  = key;
                c.wval = write_value;
                c.gap  = 0;
                replies_due.push_back(cache_access(c));
            end
        end
        cmd_taken <= rst_n && start && !busy;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // stimulus and end of test
    initial
    begin
        int idle_pct [4];
        logic [lkvc_pkg::KEY_W-1:0] key_pool [6];
        int gap;
        logic [lkvc_pkg::KEY_W-1:0] k;
        logic op;

        idle_pct = '{0, 75, 0, 34};
        for (int i = 0; i < CAPACITY; i++)
        begin
            slot_used[i] = 1'b0;
            slot_key[i]  = '0;
            slot_val[i]  = '0;
            slot_age[i]  = '0;
        end

        // directed: empty miss, fills, put hit, full evictions, key extremes
        queue_cmd(lkvc_pkg::OP_GET, 32'h8000_0000, '1, 0);
        queue_cmd(lkvc_pkg::OP_PUT, 32'h8000_0000, '1, 0);
        queue_cmd(lkvc_pkg::OP_PUT, 32'h7FFF_FFFF, '0, 0);
        queue_cmd(lkvc_pkg::OP_GET, 32'h8000_0000, '0, 0);
        queue_cmd(lkvc_pkg::OP_PUT, 32'h7FFF_FFFF, 64'h0123_4567_89AB_CDEF, 0);
        queue_cmd(lkvc_pkg::OP_GET, 32'h7FFF_FFFF, '1, 0);
        queue_cmd(lkvc_pkg::OP_PUT, 32'h0000_0000, 64'hA5A5_A5A5_A5A5_A5A5, 0);
        queue_cmd(lkvc_pkg::OP_PUT, 32'hFFFF_FFFF, 64'h5A5A_5A5A_5A5A_5A5A, 0);
        queue_cmd(lkvc_pkg::OP_GET, 32'h0000_0001, '0, 0);
        queue_cmd(lkvc_pkg::OP_PUT, 32'h0000_0001, 64'hDEAD_BEEF_CAFE_F00D, 0);
        queue_cmd(lkvc_pkg::OP_GET, 32'h8000_0000, '0, 0);
        queue_cmd(lkvc_pkg::OP_GET, 32'h0000_0000, '0, 0);
        queue_cmd(lkvc_pkg::OP_PUT, 32'h0000_0002, 64'h8000_0000_0000_0001, 0);
        queue_cmd(lkvc_pkg::OP_PUT, 32'h0000_0003, 64'h7FFF_FFFF_FFFF_FFFE, 0);
        queue_cmd(lkvc_pkg::OP_GET, 32'hFFFF_FFFF, '0, 0);
        queue_cmd(lkvc_pkg::OP_PUT, 32'h5555_5555, 64'h5555_5555_5555_5555, 0);
        queue_cmd(lkvc_pkg::OP_PUT, 32'hAAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA, 0);
        queue_cmd(lkvc_pkg::OP_GET, 32'h5555_5555, '0, 0);
        queue_cmd(lkvc_pkg::OP_PUT, 32'h5555_5555, '0, 0);
        queue_cmd(lkvc_pkg::OP_GET, 32'hAAAA_AAAA, '1, 0);
        queue_cmd(lkvc_pkg::OP_GET, 32'h5555_5555, '0, 0);

        // random: a small key set per stretch so hits, updates and evictions all occur
        for (int p = 0; p < 4; p++)
        begin
            for (int n = 0; n < RANDOM_CMDS / 4; n++)
            begin
                if (n % 60 == 0)
                begin
                    foreach (key_pool[j])
                        key_pool[j] = ($urandom_range(3) == 0) ? pick_key_extreme() : $urandom;
                end
                if ($urandom_range(99) < 85)
                    k = key_pool[$urandom_range(5)];
                else
                    k = $urandom;
                op  = ($urandom_range(1) == 0) ? lkvc_pkg::OP_GET : lkvc_pkg::OP_PUT;
                gap = 0;
                while (gap < MAX_GAP && $urandom_range(99) < idle_pct[p])
                    gap++;
                queue_cmd(op, k, pick_value(), gap);
            end
        end

        // reset
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // drain
        while (pending_cmds.size() != 0 || start)
            @(posedge clk);
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (failed || replies_due.size() != 0)
            $display("Some tests failed");
        else
            $display("All tests passed");
        $finish;
    end

endmodule
